// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the ICMP echo frame generator.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define IEFG_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: name");

// Expression never true outside reset.
`define IEFG_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition: name");

`endif

// ===== rtl/iefg_pkg.sv =====
// Shared types, constants and checksum helper for the ICMP echo frame generator.
// No dependencies.
package iefg_pkg;

    localparam int FrameLen     = 46;
    localparam int IdxW         = 6;
    localparam logic [IdxW-1:0] LastIndex = IdxW'(FrameLen - 1);
    localparam int QueueDepth   = 2;

    // Configuration register indexes
    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 48;
    localparam logic [CfgIndexW-1:0] RegDestMac     = 3'd0;
    localparam logic [CfgIndexW-1:0] RegSourceMac   = 3'd1;
    localparam logic [CfgIndexW-1:0] RegSourceIp    = 3'd2;
    localparam logic [CfgIndexW-1:0] RegDestIp      = 3'd3;
    localparam logic [CfgIndexW-1:0] RegIdentLow    = 3'd4;
    localparam logic [CfgIndexW-1:0] RegPayloadWord = 3'd5;

    localparam logic [31:0] PayloadReset = 32'h4544_474D;

    // Fixed header bytes
    localparam logic [7:0] EthTypeHi   = 8'h08;
    localparam logic [7:0] VerIhl      = 8'h45;
    localparam logic [7:0] TotLenLo    = 8'h20;
    localparam logic [7:0] FlagsDf     = 8'h40;
    localparam logic [7:0] Ttl         = 8'h80;
    localparam logic [7:0] ProtoIcmp   = 8'h01;
    localparam logic [7:0] IcmpEchoReq = 8'h08;

    // Sum of the constant 16-bit words of each header
    localparam int SumW = 19;
    localparam logic [SumW-1:0] IpConstSum   = 19'h1_0521; // 4500+0020+4000+8001
    localparam logic [SumW-1:0] IcmpConstSum = 19'h0_0800; // type 8, code 0

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [7:0]  ident_low;
        logic [31:0] payload_word;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  seq_num;
        logic [15:0] ip_csum;
        logic [15:0] icmp_csum;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // End-around carry fold of a raw sum, then one's complement.
    // Two folds suffice for SumW bits.
    function automatic logic [15:0] fold_csum(input logic [SumW-1:0] s);
        logic [16:0] t;
        logic [16:0] u;
        t = {1'b0, s[15:0]} + 17'(s[SumW-1:16]);
        u = {1'b0, t[15:0]} + 17'(t[16]);
        return ~u[15:0];
    endfunction

endpackage

// ===== rtl/iefg_front.sv =====
// Front end: accepts requests, forms raw header sums, folds them into checksums
// and pushes one entry into the queue. Depends on iefg_pkg.
module iefg_front
    import iefg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic [7:0] seq_num,
    output logic      busy,
    input  cfg_t      cfg,
    input  q_status_t q_status,
    output logic      push,
    output entry_t    push_data
);

    logic            stage_valid_reg, stage_valid_next;
    logic [7:0]      seq_reg;
    logic [SumW-1:0] ip_sum_reg, ip_sum_next;
    logic [SumW-1:0] icmp_sum_reg, icmp_sum_next;
    logic            accept;

    assign busy   = stage_valid_reg & q_status.full;
    assign accept = start & ~busy;
    assign push   = stage_valid_reg & ~q_status.full;

    assign stage_valid_next = accept | (stage_valid_reg & q_status.full);

    always_comb
    begin
        ip_sum_next = IpConstSum + SumW'(cfg.ident_low)
                    + SumW'(cfg.source_ip[31:16]) + SumW'(cfg.source_ip[15:0])
                    + SumW'(cfg.dest_ip[31:16]) + SumW'(cfg.dest_ip[15:0]);
        icmp_sum_next = IcmpConstSum + SumW'(cfg.ident_low) + SumW'(seq_num)
                      + SumW'(cfg.payload_word[31:16]) + SumW'(cfg.payload_word[15:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seq_reg      <= seq_num;
            ip_sum_reg   <= ip_sum_next;
            icmp_sum_reg <= icmp_sum_next;
        end
    end

    always_comb
    begin
        push_data.seq_num   = seq_reg;
        push_data.ip_csum   = fold_csum(ip_sum_reg);
        push_data.icmp_csum = fold_csum(icmp_sum_reg);
    end

endmodule

// ===== rtl/iefg_queue.sv =====
// Small FIFO of checksummed requests between front and back end.
// Depends on iefg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module iefg_queue
    import iefg_pkg::*;
#(
    parameter int DEPTH = QueueDepth   // 2 or more
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  entry_t    push_data,
    input  logic      pop,
    output entry_t    pop_data,
    output q_status_t q_status
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    entry_t        entries [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == CntFull);
    assign q_status.empty = (count_reg == '0);
    assign pop_data       = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    `IEFG_NEVER(a_no_overflow, clk, rst_n, push && q_status.full)
    `IEFG_NEVER(a_no_underflow, clk, rst_n, pop && q_status.empty)

endmodule

// ===== rtl/iefg_back.sv =====
// Back end: byte sequencer that walks one queued request through the 46
// frame bytes and registers each byte onto the result ports.
// Depends on iefg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module iefg_back
    import iefg_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  q_status_t       q_status,
    input  entry_t          pop_data,
    output logic            pop,
    output logic            result_valid,
    output logic [7:0]      frame_byte,
    output logic [IdxW-1:0] byte_index,
    output logic            last_byte
);

    logic            active_reg, active_next;
    logic [IdxW-1:0] idx_reg, idx_next;
    entry_t          cur_reg;
    logic            at_last;
    logic [7:0]      byte_sel;

    logic            result_valid_reg;
    logic [7:0]      frame_byte_reg;
    logic [IdxW-1:0] byte_index_reg;
    logic            last_byte_reg;

    assign at_last = (idx_reg == LastIndex);
    assign pop     = (~active_reg | at_last) & ~q_status.empty;

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        if (pop)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
        else if (active_reg)
        begin
            if (at_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        case (idx_reg)
            6'd0:  byte_sel = cfg.dest_mac[47:40];
            6'd1:  byte_sel = cfg.dest_mac[39:32];
            6'd2:  byte_sel = cfg.dest_mac[31:24];
            6'd3:  byte_sel = cfg.dest_mac[23:16];
            6'd4:  byte_sel = cfg.dest_mac[15:8];
            6'd5:  byte_sel = cfg.dest_mac[7:0];
            6'd6:  byte_sel = cfg.source_mac[47:40];
            6'd7:  byte_sel = cfg.source_mac[39:32];
            6'd8:  byte_sel = cfg.source_mac[31:24];
            6'd9:  byte_sel = cfg.source_mac[23:16];
            6'd10: byte_sel = cfg.source_mac[15:8];
            6'd11: byte_sel = cfg.source_mac[7:0];
            6'd12: byte_sel = EthTypeHi;
            6'd14: byte_sel = VerIhl;
            6'd17: byte_sel = TotLenLo;
            6'd19: byte_sel = cfg.ident_low;
            6'd20: byte_sel = FlagsDf;
            6'd22: byte_sel = Ttl;
            6'd23: byte_sel = ProtoIcmp;
            6'd24: byte_sel = cur_reg.ip_csum[15:8];
            6'd25: byte_sel = cur_reg.ip_csum[7:0];
            6'd26: byte_sel = cfg.source_ip[31:24];
            6'd27: byte_sel = cfg.source_ip[23:16];
            6'd28: byte_sel = cfg.source_ip[15:8];
            6'd29: byte_sel = cfg.source_ip[7:0];
            6'd30: byte_sel = cfg.dest_ip[31:24];
            6'd31: byte_sel = cfg.dest_ip[23:16];
            6'd32: byte_sel = cfg.dest_ip[15:8];
            6'd33: byte_sel = cfg.dest_ip[7:0];
            6'd34: byte_sel = IcmpEchoReq;
            6'd36: byte_sel = cur_reg.icmp_csum[15:8];
            6'd37: byte_sel = cur_reg.icmp_csum[7:0];
            6'd39: byte_sel = cfg.ident_low;
            6'd41: byte_sel = cur_reg.seq_num;
            6'd42: byte_sel = cfg.payload_word[31:24];
            6'd43: byte_sel = cfg.payload_word[23:16];
            6'd44: byte_sel = cfg.payload_word[15:8];
            6'd45: byte_sel = cfg.payload_word[7:0];
            default: byte_sel = 8'h00;   // zero bytes of the headers
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg       <= active_next;
            idx_reg          <= idx_next;
            result_valid_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_data;
        end
        frame_byte_reg <= byte_sel;
        byte_index_reg <= idx_reg;
        last_byte_reg  <= at_last;
    end

    assign result_valid = result_valid_reg;
    assign frame_byte   = frame_byte_reg;
    assign byte_index   = byte_index_reg;
    assign last_byte    = last_byte_reg;

    `IEFG_ASSERT(a_last_at_end, clk, rst_n,
        result_valid && last_byte |-> byte_index == LastIndex)
    `IEFG_ASSERT(a_index_steps, clk, rst_n,
        result_valid && byte_index != '0 |->
            $past(result_valid) && byte_index == IdxW'($past(byte_index) + 1'b1))
    `IEFG_ASSERT(a_frame_starts_clean, clk, rst_n,
        result_valid && byte_index == '0 |-> !$past(result_valid) || $past(last_byte))

endmodule

// ===== rtl/icmp_echo_frame_generator.sv =====
// Top level of the ICMP echo-request frame generator: configuration registers,
// front end, request queue and byte sequencer. Depends on iefg_pkg and its submodules.
//
//  channel   | signals                                  | transaction when
//  ----------+------------------------------------------+-------------------------
//  request   | start, busy, seq_num                     | start & !busy at clk edge
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid & cfg_ready
//  result    | result_valid, frame_byte, byte_index,    | every cycle result_valid
//            | last_byte                                |   is high (no stall)
//
// Each request produces 46 result transactions, one per cycle, byte 0 first,
// last_byte high on byte 45. The byte sequencer sets the rate: frames go back to
// back with no gap while requests are queued. A request passes the checksum
// stage register, the queue and the sequencer state before byte 0 is registered.
// The front end takes a new request while a frame is still being sent; busy
// rises only when the checksum stage holds a request and the queue is full.
// rst_n clears all control state and loads register reset values; results
// cannot be stalled, so nothing ever waits on the output side.
module icmp_echo_frame_generator
    import iefg_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request
    input  logic                 start,
    output logic                 busy,
    input  logic [7:0]           seq_num,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data,
    // result
    output logic                 result_valid,
    output logic [7:0]           frame_byte,
    output logic [IdxW-1:0]      byte_index,
    output logic                 last_byte
);

    cfg_t      cfg_reg;
    q_status_t q_status;
    logic      push;
    logic      pop;
    entry_t    push_data;
    entry_t    pop_data;

    // Registers are always writable; writes to unused indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_mac     <= '0;
            cfg_reg.source_mac   <= '0;
            cfg_reg.source_ip    <= '0;
            cfg_reg.dest_ip      <= '0;
            cfg_reg.ident_low    <= '0;
            cfg_reg.payload_word <= PayloadReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                RegDestMac:     cfg_reg.dest_mac     <= cfg_data[47:0];
                RegSourceMac:   cfg_reg.source_mac   <= cfg_data[47:0];
                RegSourceIp:    cfg_reg.source_ip    <= cfg_data[31:0];
                RegDestIp:      cfg_reg.dest_ip      <= cfg_data[31:0];
                RegIdentLow:    cfg_reg.ident_low    <= cfg_data[7:0];
                RegPayloadWord: cfg_reg.payload_word <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Front end: request capture and checksum computation
    iefg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .seq_num   (seq_num),
        .busy      (busy),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // Decouples checksum stage from the byte sequencer
    iefg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    // Back end: emits the frame one byte per cycle
    iefg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_status     (q_status),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .frame_byte   (frame_byte),
        .byte_index   (byte_index),
        .last_byte    (last_byte)
    );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for icmp_echo_frame_generator: directed and random requests,
// register writes between phases, byte-by-byte frame checking. Depends on iefg_pkg.
`timescale 1ns / 1ps

module testbench;
    import iefg_pkg::*;

    localparam int ClkHalfPeriod = 10;
    localparam int ResetCycles   = 12;
    localparam int CycleLimit    = 300000;
    // Settle well past the request-to-byte-0 latency.
    localparam int SettleCycles  = 20;
    localparam int RandomPhases  = 8;
    localparam int PhaseRequests = 40;
    localparam logic [CfgIndexW-1:0] RegSpareFirst = RegPayloadWord + 1'b1;
    localparam logic [CfgIndexW-1:0] RegSpareLast  = {CfgIndexW{1'b1}};

    // One expected result transaction.
    typedef struct packed {
        logic [7:0]      data;
        logic [IdxW-1:0] index;
        logic            last;
    } frame_entry_t;

    // Mirrors the register file, builds each frame on request acceptance
    // and compares every emitted byte with the oldest pending one.
    class frame_scoreboard;
        cfg_t         regs;
        logic [7:0]   frame_bytes [FrameLen];
        frame_entry_t pending_q [$];
        int unsigned  errors;

        function new();
            regs.dest_mac     = '0;
            regs.source_mac   = '0;
            regs.source_ip    = '0;
            regs.dest_ip      = '0;
            regs.ident_low    = '0;
            regs.payload_word = PayloadReset;
            errors            = 0;
        endfunction

        // Unused indexes are dropped; upper data bits masked by register width.
        function void set_register(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] value);
            case (idx)
                RegDestMac:     regs.dest_mac     = value[47:0];
                RegSourceMac:   regs.source_mac   = value[47:0];
                RegSourceIp:    regs.source_ip    = value[31:0];
                RegDestIp:      regs.dest_ip      = value[31:0];
                RegIdentLow:    regs.ident_low    = value[7:0];
                RegPayloadWord: regs.payload_word = value[31:0];
                default: ;
            endcase
        endfunction

        // Internet checksum over frame_bytes, carries folded until none remain.
        function logic [15:0] inet_checksum(int first, int count);
            logic [31:0] acc;
            int          k;
            acc = 0;
            for (k = 0; k + 1 < count; k += 2)
                acc += {16'h0, frame_bytes[first + k], frame_bytes[first + k + 1]};
            while (acc[31:16] != 0)
                acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
            return ~acc[15:0];
        endfunction

        function void note_request(logic [7:0] seq);
            logic [15:0]  csum;
            frame_entry_t entry;
            int           k;
            for (k = 0; k < FrameLen; k++)
                frame_bytes[k] = 8'h00;
            for (k = 0; k < 6; k++)
            begin
                frame_bytes[k]     = regs.dest_mac[8*(5-k) +: 8];
                frame_bytes[6 + k] = regs.source_mac[8*(5-k) +: 8];
            end
            frame_bytes[12] = EthTypeHi;
            frame_bytes[14] = VerIhl;
            frame_bytes[17] = TotLenLo;
            frame_bytes[19] = regs.ident_low;
            frame_bytes[20] = FlagsDf;
            frame_bytes[22] = Ttl;
            frame_bytes[23] = ProtoIcmp;
            for (k = 0; k < 4; k++)
            begin
                frame_bytes[26 + k] = regs.source_ip[8*(3-k) +: 8];
                frame_bytes[30 + k] = regs.dest_ip[8*(3-k) +: 8];
                frame_bytes[42 + k] = regs.payload_word[8*(3-k) +: 8];
            end
            frame_bytes[34] = IcmpEchoReq;
            frame_bytes[39] = regs.ident_low;
            frame_bytes[41] = seq;
            // Checksum fields are still zero while summing.
            csum = inet_checksum(14, 20);
            frame_bytes[24] = csum[15:8];
            frame_bytes[25] = csum[7:0];
            csum = inet_checksum(34, 12);
            frame_bytes[36] = csum[15:8];
            frame_bytes[37] = csum[7:0];
            for (k = 0; k < FrameLen; k++)
            begin
                entry.data  = frame_bytes[k];
                entry.index = IdxW'(k);
                entry.last  = (k == FrameLen - 1);
                pending_q.push_back(entry);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_byte(logic [7:0] data, logic [IdxW-1:0] index, logic last);
            frame_entry_t want;
            if (pending_q.size() == 0)
            begin
                report($sformatf("unexpected byte %02h at index %0d", data, index));
                return;
            end
            want = pending_q.pop_front();
            if (data !== want.data)
                report($sformatf("frame_byte %02h, want %02h (byte %0d)",
                                 data, want.data, want.index));
            if (index !== want.index)
                report($sformatf("byte_index %0d, want %0d", index, want.index));
            if (last !== want.last)
                report($sformatf("last_byte %b, want %b (byte %0d)",
                                 last, want.last, want.index));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [7:0]           seq_num;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_data;
    logic                 result_valid;
    logic [7:0]           frame_byte;
    logic [IdxW-1:0]      byte_index;
    logic                 last_byte;

    frame_scoreboard sb;
    int unsigned     cycle_count;

    icmp_echo_frame_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .seq_num      (seq_num),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .frame_byte   (frame_byte),
        .byte_index   (byte_index),
        .last_byte    (last_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #ClkHalfPeriod clk = ~clk;
    end

    // Watchdog: cycle budget covers every request with a long sender gap.
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CycleLimit);
        $display("tb: failure");
        $finish;
    end

    // Result side cannot be stalled: every strobed cycle is a transaction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_byte(frame_byte, byte_index, last_byte);
    end

    // Register write transaction; valid dropped on the following falling edge.
    task write_register(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_register(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task write_all(logic [CfgDataW-1:0] dmac, logic [CfgDataW-1:0] smac,
                   logic [CfgDataW-1:0] sip, logic [CfgDataW-1:0] dip,
                   logic [CfgDataW-1:0] ident, logic [CfgDataW-1:0] payload);
        write_register(RegDestMac, dmac);
        write_register(RegSourceMac, smac);
        write_register(RegSourceIp, sip);
        write_register(RegDestIp, dip);
        write_register(RegIdentLow, ident);
        write_register(RegPayloadWord, payload);
    endtask

    // Raise start with a new sequence number and hold until the request
    // transaction (start high, busy low at the rising edge). start is left
    // high so a back-to-back request needs no extra edge.
    task send_request(logic [7:0] seq);
        @(negedge clk);
        start   <= 1'b1;
        seq_num <= seq;
        do @(posedge clk); while (busy);
        sb.note_request(seq);
    endtask

    task idle_sender(int cycles);
        @(negedge clk);
        start   <= 1'b0;
        seq_num <= 8'($urandom);
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Sender holds off until every expected byte has arrived.
    task drain_frames();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Mostly back to back or short gaps, a few long ones.
    task random_gap(bit burst);
        int pick;
        pick = $urandom_range(0, 99);
        if (burst || pick < 55)
            return;
        if (pick < 90)
            idle_sender($urandom_range(1, 3));
        else
            idle_sender($urandom_range(10, 80));
    endtask

    function automatic logic [CfgDataW-1:0] pick_value();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return raw[CfgDataW-1:0];
        endcase
    endfunction

    initial
    begin
        int  phase;
        int  n;
        bit  burst;

        sb          = new();
        cycle_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        seq_num     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (ResetCycles) @(negedge clk);
        rst_n = 1'b1;

        // Register reset values, including the default payload.
        send_request(8'h00);
        send_request(8'hFF);
        drain_frames();

        // All ones everywhere: high data bits must be masked per register.
        write_all('1, '1, '1, '1, '1, '1);
        send_request(8'hFF);
        idle_sender(2);
        send_request(8'h00);
        send_request(8'hAA);
        send_request(8'h55);
        drain_frames();

        // One's-complement sums of all ones: both checksums come out zero.
        // IP: 0x0522 folded constants + 0xFADD; ICMP: 0x0800 + 0xF7FF.
        write_all(48'h0123_4567_89AB, 48'hFEDC_BA98_7654, 48'hFADD_0000, 48'h0,
                  48'h0, 48'hF7FF_0000);
        // Writes to unused indexes must change nothing.
        write_register(RegSpareFirst, '1);
        write_register(RegSpareLast, 48'hA5A5_A5A5_A5A5);
        send_request(8'h00);
        drain_frames();

        // Raw sums of 0x1FFFF: the first fold carries again, so both
        // checksums need a second end-around carry.
        write_register(RegSourceIp, 48'hFADE_0000);
        write_register(RegPayloadWord, 48'hFFFF_F800);
        send_request(8'h00);
        drain_frames();

        // All zeros.
        write_all('0, '0, '0, '0, '0, '0);
        send_request(8'h01);
        send_request(8'h80);
        idle_sender(5);
        send_request(8'h7F);
        drain_frames();

        // Random phases: new register settings, then a stream of requests.
        for (phase = 0; phase < RandomPhases; phase++)
        begin
            write_all(pick_value(), pick_value(), pick_value(), pick_value(),
                      pick_value(), pick_value());
            if ($urandom_range(0, 2) == 0)
                write_register(CfgIndexW'($urandom_range(RegSpareFirst, RegSpareLast)),
                               pick_value());
            burst = ($urandom_range(0, 3) == 0);
            for (n = 0; n < PhaseRequests; n++)
            begin
                send_request(8'($urandom));
                random_gap(burst);
                // Occasional full drain in the middle of a stream.
                if (!burst && $urandom_range(0, 59) == 0)
                    drain_frames();
            end
            drain_frames();
        end

        drain_frames();
        if (sb.pending_q.size() != 0)
            sb.report($sformatf("%0d bytes never arrived", sb.pending_q.size()));
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/iefg_pkg.sv
rtl/iefg_front.sv
rtl/iefg_queue.sv
rtl/iefg_back.sv
rtl/icmp_echo_frame_generator.sv
dv/testbench.sv
